// ===== hdl/premultiplied_over_straight_rgba_assert.svh =====
// Assertion macros for the pixel compositing block
`ifndef PREMULTIPLIED_OVER_STRAIGHT_RGBA_ASSERT_SVH
`define PREMULTIPLIED_OVER_STRAIGHT_RGBA_ASSERT_SVH

`ifndef SYNTHESIS
`define POBS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pobs: next-cycle check failed");
`define POBS_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pobs: same-cycle check failed");
`else
`define POBS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`define POBS_ASSERT_NOW(lbl, clk, rst, pre, post)
`endif

`endif

// ===== hdl/pobs_pkg.sv =====
package pobs_pkg;

   localparam int CHAN_W    = 8;
   localparam int NUM_LANES = 3;
   localparam int W_W       = 16;
   localparam int NUM_W     = 25;
   localparam int DEN_W     = 17;
   // saturation check plus one step per quotient bit
   localparam int DIV_STEPS = CHAN_W + 1;
   // numerator register plus divider steps
   localparam int LANE_LAT  = DIV_STEPS + 1;

   typedef enum logic [1:0] {
      MODE_UNPREMUL,
      MODE_COPY_DST,
      MODE_OVER
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [CHAN_W-1:0]   src_alpha;
      logic [CHAN_W-1:0]   dst_red;
      logic [CHAN_W-1:0]   dst_green;
      logic [CHAN_W-1:0]   dst_blue;
      logic [CHAN_W-1:0]   dst_alpha;
      logic [CHAN_W-1:0]   over_alpha;
      logic                last;
   } side_type;

   // floor(x / 255) for x up to 255 * 255
   function automatic logic [CHAN_W-1:0] div255(input logic [W_W-1:0] x);
      logic [W_W:0] t;
      t = (W_W+1)'(x) + (W_W+1)'(x >> 8) + (W_W+1)'(1);
      return t[W_W-1:8];
   endfunction

endpackage

// ===== hdl/pobs_lane.sv =====
module pobs_lane
   import pobs_pkg::*;
(
   input  logic              clock,
   input  logic [CHAN_W-1:0] src_c,
   input  logic [CHAN_W-1:0] dst_c,
   input  logic [CHAN_W-1:0] src_alpha,
   input  logic [W_W-1:0]    weight,
   input  logic [DEN_W-1:0]  divisor,
   input  logic              over_mode,
   output logic [CHAN_W-1:0] quotient
);

   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [NUM_W-1:0]  rem_ff [DIV_STEPS];
   logic [DEN_W-1:0]  dsr_ff [DIV_STEPS];
   logic [CHAN_W-1:0] quo_ff [DIV_STEPS];
   logic              sat_ff [DIV_STEPS];
   logic [NUM_W-1:0]  rem_in [DIV_STEPS];
   logic [CHAN_W-1:0] quo_in [DIV_STEPS];
   logic [NUM_W-1:0]  trial  [DIV_STEPS];

   // form numerator and divisor
   always_ff @(posedge clock) begin
      if (over_mode) begin
         num_ff <= NUM_W'(src_c) * NUM_W'(65025) + NUM_W'(weight) * NUM_W'(dst_c);
         den_ff <= divisor;
      end else begin
         num_ff <= NUM_W'(src_c) * NUM_W'(255);
         den_ff <= DEN_W'(src_alpha);
      end
   end

   // one restoring step per stage after the saturation stage, most significant bit first
   always_comb begin
      rem_in[0] = num_ff;
      quo_in[0] = '0;
      trial[0]  = NUM_W'(den_ff) << CHAN_W;
      for (int i = 1; i < DIV_STEPS; i++) begin
         trial[i]  = NUM_W'(dsr_ff[i-1]) << (DIV_STEPS - 1 - i);
         rem_in[i] = rem_ff[i-1];
         quo_in[i] = quo_ff[i-1];
         if (rem_ff[i-1] >= trial[i]) begin
            rem_in[i] = rem_ff[i-1] - trial[i];
            quo_in[i][DIV_STEPS-1-i] = 1'b1;
         end
      end
   end

   // advance the divider stages
   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      quo_ff[0] <= quo_in[0];
      dsr_ff[0] <= den_ff;
      sat_ff[0] <= (num_ff >= trial[0]);
      for (int i = 1; i < DIV_STEPS; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
         dsr_ff[i] <= dsr_ff[i-1];
         sat_ff[i] <= sat_ff[i-1];
      end
   end

   assign quotient = sat_ff[DIV_STEPS-1] ? {CHAN_W{1'b1}} : quo_ff[DIV_STEPS-1];

endmodule

// ===== hdl/premultiplied_over_straight_rgba.sv =====
// A result passes the capture registers, the lane numerator register, the divider stages and the output register.
// Throughput: one pixel per cycle; busy is high only during reset.
// Three channel lanes each hold a numerator register and a 9-stage pipelined
// restoring divider.
// Reset clears the valid pipeline and sets blend_enable to 0.
// The receiver cannot stall; rsp_valid pulses for one cycle per result.
`include "premultiplied_over_straight_rgba_assert.svh"

module premultiplied_over_straight_rgba
   import pobs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_blend_enable,
   input  logic              req_start,
   output logic              busy,
   input  logic [CHAN_W-1:0] req_src_red,
   input  logic [CHAN_W-1:0] req_src_green,
   input  logic [CHAN_W-1:0] req_src_blue,
   input  logic [CHAN_W-1:0] req_src_alpha,
   input  logic [CHAN_W-1:0] req_dst_red,
   input  logic [CHAN_W-1:0] req_dst_green,
   input  logic [CHAN_W-1:0] req_dst_blue,
   input  logic [CHAN_W-1:0] req_dst_alpha,
   input  logic              req_last_pixel,
   output logic              rsp_valid,
   output logic [CHAN_W-1:0] rsp_out_red,
   output logic [CHAN_W-1:0] rsp_out_green,
   output logic [CHAN_W-1:0] rsp_out_blue,
   output logic [CHAN_W-1:0] rsp_out_alpha,
   output logic              rsp_out_last
);

   logic              blend_ff;
   logic              accept;
   logic [CHAN_W-1:0] inv_sa;
   mode_type          mode_in;

   logic              s1_valid_ff;
   mode_type          s1_mode_ff;
   logic [CHAN_W-1:0] s1_src_ff [NUM_LANES];
   logic [CHAN_W-1:0] s1_dst_ff [NUM_LANES];
   logic [CHAN_W-1:0] s1_sa_ff;
   logic [CHAN_W-1:0] s1_da_ff;
   logic              s1_last_ff;
   logic [W_W-1:0]    w_ff;
   logic [W_W-1:0]    x_ff;

   logic [DEN_W-1:0]  den;
   side_type          side_in;
   side_type          side_ff [LANE_LAT];
   logic              vpipe_ff [LANE_LAT];
   logic [CHAN_W-1:0] quo [NUM_LANES];
   side_type          side_out;

   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic              last_ff;

   logic              out_go;
   logic              out_over;
   logic              out_clear;
   logic              rgb_zero;

   assign busy      = reset;
   assign accept    = req_start & ~busy;
   assign csr_ready = 1'b1;

   // hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         blend_ff <= csr_blend_enable;
      end
   end

   // classify the pixel
   assign inv_sa = 8'hFF - req_src_alpha;
   always_comb begin
      if (!blend_ff || (req_src_alpha != '0 &&
          (req_dst_alpha == '0 || req_src_alpha == 8'hFF))) begin
         mode_in = MODE_UNPREMUL;
      end else if (req_src_alpha == '0) begin
         mode_in = MODE_COPY_DST;
      end else begin
         mode_in = MODE_OVER;
      end
   end

   // capture the transfer and form the weights
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff   <= mode_in;
      s1_src_ff[0] <= req_src_red;
      s1_src_ff[1] <= req_src_green;
      s1_src_ff[2] <= req_src_blue;
      s1_dst_ff[0] <= req_dst_red;
      s1_dst_ff[1] <= req_dst_green;
      s1_dst_ff[2] <= req_dst_blue;
      s1_sa_ff     <= req_src_alpha;
      s1_da_ff     <= req_dst_alpha;
      s1_last_ff   <= req_last_pixel;
      w_ff         <= W_W'(inv_sa) * W_W'(req_dst_alpha);
      x_ff         <= W_W'(inv_sa) * W_W'(8'hFF - req_dst_alpha);
   end

   assign den = DEN_W'(s1_sa_ff) * DEN_W'(255) + DEN_W'(w_ff);

   always_comb begin
      side_in.mode       = s1_mode_ff;
      side_in.src_alpha  = s1_sa_ff;
      side_in.dst_red    = s1_dst_ff[0];
      side_in.dst_green  = s1_dst_ff[1];
      side_in.dst_blue   = s1_dst_ff[2];
      side_in.dst_alpha  = s1_da_ff;
      side_in.over_alpha = 8'hFF - div255(x_ff);
      side_in.last       = s1_last_ff;
   end

   // channel lanes
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      pobs_lane u_lane (
         .clock     (clock),
         .src_c     (s1_src_ff[g]),
         .dst_c     (s1_dst_ff[g]),
         .src_alpha (s1_sa_ff),
         .weight    (w_ff),
         .divisor   (den),
         .over_mode (s1_mode_ff == MODE_OVER),
         .quotient  (quo[g])
      );
   end

   // delay sideband alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) vpipe_ff[i] <= 1'b0;
      end else begin
         vpipe_ff[0] <= s1_valid_ff;
         for (int i = 1; i < LANE_LAT; i++) vpipe_ff[i] <= vpipe_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < LANE_LAT; i++) side_ff[i] <= side_ff[i-1];
   end

   assign side_out = side_ff[LANE_LAT-1];

   // merge lane results into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vpipe_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= side_out.last;
      case (side_out.mode)
         MODE_COPY_DST: begin
            red_ff   <= side_out.dst_red;
            green_ff <= side_out.dst_green;
            blue_ff  <= side_out.dst_blue;
            alpha_ff <= side_out.dst_alpha;
         end
         MODE_OVER: begin
            red_ff   <= quo[0];
            green_ff <= quo[1];
            blue_ff  <= quo[2];
            alpha_ff <= side_out.over_alpha;
         end
         default: begin
            if (side_out.src_alpha == '0) begin
               red_ff   <= '0;
               green_ff <= '0;
               blue_ff  <= '0;
            end else begin
               red_ff   <= quo[0];
               green_ff <= quo[1];
               blue_ff  <= quo[2];
            end
            alpha_ff <= side_out.src_alpha;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_out_alpha = alpha_ff;
   assign rsp_out_last  = last_ff;

   // conditions watched by the checks below
   assign out_go    = vpipe_ff[LANE_LAT-1];
   assign out_over  = out_go && side_out.mode == MODE_OVER;
   assign out_clear = out_go && side_out.mode == MODE_UNPREMUL && side_out.src_alpha == '0;
   assign rgb_zero  = rsp_out_red == '0 && rsp_out_green == '0 && rsp_out_blue == '0;

   // over never lowers alpha below the source alpha
   `POBS_ASSERT_NEXT(a_over_alpha, clock, reset, out_over, rsp_out_alpha >= $past(side_out.src_alpha))
   // a transparent source converts to black
   `POBS_ASSERT_NEXT(a_zero_alpha, clock, reset, out_clear, rgb_zero)
   // every lane result leaves as one strobe
   `POBS_ASSERT_NEXT(a_strobe, clock, reset, out_go, rsp_valid)

endmodule

// ===== test/tb_premultiplied_over_straight_rgba.sv =====
`timescale 1ns / 1ps

module tb_premultiplied_over_straight_rgba;
   import pobs_pkg::*;

   localparam int N_RANDOM   = 1950;
   localparam int LATENCY    = 12;
   localparam int IDLE_LIMIT = 2000;

   typedef struct {
      logic [7:0] sr, sg, sb, sa, dr, dg, db, da;
      logic       last;
      bit         is_cfg;  // a mode change, applied once the pipe drains
      bit         blend;
      bit         drain;   // hold off until every result has come
   } pixel_job_type;

   typedef struct {
      logic [7:0] r, g, b, a;
      logic       last;
   } pixel_out_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0, csr_blend_enable = 0, req_start = 0;
   logic [7:0] req_src_red = 0, req_src_green = 0, req_src_blue = 0, req_src_alpha = 0;
   logic [7:0] req_dst_red = 0, req_dst_green = 0, req_dst_blue = 0, req_dst_alpha = 0;
   logic req_last_pixel = 0;
   logic csr_ready, busy, rsp_valid, rsp_out_last;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;

   pixel_job_type job_q[$];
   pixel_out_type composite_q[$];
   bit         blend_mode = 0;
   int         fail_count = 0;
   int         idle_cycles = 0;
   bit         stim_done = 0;

   premultiplied_over_straight_rgba u_top (.*);

   always #10 clock = ~clock;

   function automatic logic [7:0] unpremultiply(logic [7:0] c, logic [7:0] a);
      int unsigned q;
      if (a == 0) return 8'd0;
      q = (c * 255) / a;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic logic [7:0] over_channel(logic [7:0] cs, logic [7:0] cd,
                                               logic [7:0] sa, logic [7:0] da);
      int unsigned w, den, q;
      w   = (255 - sa) * da;
      den = sa * 255 + w;
      q   = (cs * 65025 + w * cd) / den;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic pixel_out_type predict_pixel(pixel_job_type j, bit blend);
      pixel_out_type o;
      o.last = j.last;
      if (!blend || (j.sa != 0 && (j.da == 0 || j.sa == 255))) begin
         o.r = unpremultiply(j.sr, j.sa);
         o.g = unpremultiply(j.sg, j.sa);
         o.b = unpremultiply(j.sb, j.sa);
         o.a = j.sa;
      end else if (j.sa == 0) begin
         o.r = j.dr; o.g = j.dg; o.b = j.db; o.a = j.da;
      end else begin
         o.r = over_channel(j.sr, j.dr, j.sa, j.da);
         o.g = over_channel(j.sg, j.dg, j.sa, j.da);
         o.b = over_channel(j.sb, j.db, j.sa, j.da);
         o.a = 8'(255 - ((255 - j.sa) * (255 - j.da)) / 255);
      end
      return o;
   endfunction

   function automatic pixel_job_type pixel(int sr, int sg, int sb, int sa,
                                           int dr, int dg, int db, int da, bit last);
      pixel_job_type j;
      j = '{default: 0};
      j.sr = 8'(sr); j.sg = 8'(sg); j.sb = 8'(sb); j.sa = 8'(sa);
      j.dr = 8'(dr); j.dg = 8'(dg); j.db = 8'(db); j.da = 8'(da); j.last = last;
      return j;
   endfunction

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd1;
         3: return 8'd254;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_job_type random_pixel();
      pixel_job_type j;
      j = pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                1'($urandom_range(0, 1)));
      // mostly well-formed premultiplied colors
      if ($urandom_range(0, 3) != 0) begin
         j.sr = 8'($urandom_range(0, j.sa));
         j.sg = 8'($urandom_range(0, j.sa));
         j.sb = 8'($urandom_range(0, j.sa));
      end
      return j;
   endfunction

   task automatic push_mode(bit blend);
      pixel_job_type j;
      j = '{default: 0};
      j.is_cfg = 1;
      j.blend  = blend;
      job_q.push_back(j);
   endtask

   // fill the job queue: directed corners, then random phases per mode
   initial begin
      pixel_job_type j;
      bit m;
      for (int pass = 0; pass < 2; pass++) begin
         push_mode(pass[0]);
         job_q.push_back(pixel(0, 0, 0, 0, 255, 255, 255, 255, 0));
         job_q.push_back(pixel(255, 255, 255, 255, 0, 0, 0, 0, 1));
         job_q.push_back(pixel(128, 64, 1, 128, 10, 20, 30, 200, 0));
         job_q.push_back(pixel(255, 200, 100, 1, 9, 8, 7, 100, 0));
         job_q.push_back(pixel(50, 40, 30, 60, 1, 2, 3, 0, 1));
         job_q.push_back(pixel(1, 2, 0, 1, 255, 0, 255, 255, 0));
         job_q.push_back(pixel(254, 1, 127, 254, 254, 1, 128, 1, 0));
         job_q.push_back(pixel(0, 0, 0, 0, 0, 0, 0, 0, 1));
         job_q.push_back(pixel(85, 170, 255, 255, 170, 85, 0, 128, 0));
         job_q.push_back(pixel(100, 100, 100, 128, 255, 255, 255, 255, 0));
         job_q.push_back(pixel(255, 255, 255, 128, 0, 128, 255, 64, 1));
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 400 == 0) begin
            m = $urandom_range(0, 3) != 0;
            push_mode(m);
         end
         j = random_pixel();
         j.drain = (i == 777);
         job_q.push_back(j);
      end
      push_mode(0);
   end

   // driver: bursts with random gaps, mode writes only while drained
   int burst_left = 0, gap_left = 0, settle = 0;
   always @(negedge clock) begin
      pixel_job_type j;
      if (reset) begin
         req_start <= 0;
         csr_valid <= 0;
      end else if (csr_valid) begin
         if (csr_ready) begin
            csr_valid  <= 0;
            blend_mode <= csr_blend_enable;
         end
      end else if (req_start && busy) begin
         // hold the item until it transfers
      end else if (job_q.size() == 0) begin
         req_start <= 0;
         if (composite_q.size() == 0) stim_done <= 1;
      end else if (job_q[0].is_cfg || job_q[0].drain) begin
         req_start <= 0;
         if (composite_q.size() != 0) settle <= 0;
         else if (settle < LATENCY + 2) settle <= settle + 1;
         else begin
            j = job_q.pop_front();
            settle <= 0;
            if (j.is_cfg) begin
               csr_valid        <= 1;
               csr_blend_enable <= j.blend;
            end else begin
               job_q.push_front(j);
               job_q[0].drain = 0;
            end
         end
      end else if (gap_left > 0) begin
         req_start <= 0;
         gap_left  <= gap_left - 1;
      end else begin
         j = job_q.pop_front();
         req_start      <= 1;
         req_src_red    <= j.sr; req_src_green <= j.sg;
         req_src_blue   <= j.sb; req_src_alpha <= j.sa;
         req_dst_red    <= j.dr; req_dst_green <= j.dg;
         req_dst_blue   <= j.db; req_dst_alpha <= j.da;
         req_last_pixel <= j.last;
         if (burst_left > 0) burst_left <= burst_left - 1;
         else begin
            burst_left <= $urandom_range(0, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
      end
   end

   // monitor: predict on request transfer, check on each result strobe
   always @(posedge clock) begin
      pixel_job_type j;
      pixel_out_type e;
      if (!reset) begin
         if (req_start && !busy) begin
            j = pixel(req_src_red, req_src_green, req_src_blue, req_src_alpha,
                      req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha,
                      req_last_pixel);
            composite_q.push_back(predict_pixel(j, blend_mode));
         end
         if (rsp_valid) begin
            if (composite_q.size() == 0) begin
               $error("result with nothing expected");
               fail_count++;
            end else begin
               e = composite_q.pop_front();
               if (rsp_out_red !== e.r) begin
                  $error("out_red exp %0d got %0d", e.r, rsp_out_red); fail_count++;
               end
               if (rsp_out_green !== e.g) begin
                  $error("out_green exp %0d got %0d", e.g, rsp_out_green); fail_count++;
               end
               if (rsp_out_blue !== e.b) begin
                  $error("out_blue exp %0d got %0d", e.b, rsp_out_blue); fail_count++;
               end
               if (rsp_out_alpha !== e.a) begin
                  $error("out_alpha exp %0d got %0d", e.a, rsp_out_alpha); fail_count++;
               end
               if (rsp_out_last !== e.last) begin
                  $error("out_last exp %0d got %0d", e.last, rsp_out_last); fail_count++;
               end
            end
         end
         if ((req_start && !busy) || rsp_valid || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // reset, then wait for the end or the watchdog
   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      while (!stim_done && idle_cycles < IDLE_LIMIT) @(posedge clock);
      if (!stim_done) begin
         $display("tb_premultiplied_over_straight_rgba: FAIL");
      end else begin
         repeat (LATENCY + 8) @(posedge clock);
         if (fail_count == 0 && composite_q.size() == 0)
            $display("tb_premultiplied_over_straight_rgba: PASS");
         else
            $display("tb_premultiplied_over_straight_rgba: FAIL");
      end
      $finish;
   end

endmodule
